>>> rtl/bsbp_pkg.sv
// bsbp_pkg: types, constants and elaboration-time table builders for the
// beam-search best-path tracer; no dependencies
`timescale 1ns / 1ps

package bsbp_pkg;

	localparam int MAX_STEPS_DEF = 16;
	localparam int MAX_BEAM_DEF  = 16;
	localparam int RESULT_CAP    = 16;
	localparam int JOB_IDX_W     = 6;   // covers up to 64 steps or slots
	localparam int LOG_W         = 23;  // log2 value, Q16
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [23:0] EOS_TOKEN = 24'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEAM_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_PEN    = 2'd2;

	typedef struct packed {
		logic [23:0]        token;
		logic signed [31:0] score;
		logic [3:0]         parent_slot;
	} cell_t;

	typedef struct packed {
		logic [23:0] out_token;
		logic        is_last;
		logic        is_empty;
	} result_t;

	// classified cell handed from front to back
	typedef struct packed {
		logic [23:0]          token;
		logic signed [31:0]   score;
		logic [3:0]           parent;
		logic [JOB_IDX_W-1:0] step;
		logic [JOB_IDX_W-1:0] slot;
		logic                 need_score;
		logic                 last_cell;
		logic                 restart;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOG,
		B_EXP,
		B_MAG,
		B_SAT,
		B_CMP,
		B_TR_INIT,
		B_TR_RD,
		B_TR_WB,
		B_TR_FIN,
		B_EMIT
	} bsbp_state_t;

	// log2(n) in Q16 by repeated squaring of the mantissa
	function automatic longint unsigned fx_log2(input int unsigned n);
		int unsigned       k;
		longint unsigned   x;
		longint unsigned   frac;
		k = 0;
		frac = 0;
		while (k < 31 && (n >> (k + 1)) != 0) k++;
		x = (longint'(n) << 30) >> k;
		for (int it = 0; it < 16; it++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				frac = frac | 64'd1;
			end
		end
		return (longint'(k) << 16) | frac;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned res;
		longint unsigned bitw;
		v = v_in;
		res = 0;
		bitw = 64'd1 << 62;
		while (bitw > v) bitw = bitw >> 2;
		while (bitw != 0) begin
			if (v >= res + bitw) begin
				v = v - (res + bitw);
				res = (res >> 1) + bitw;
			end else begin
				res = res >> 1;
			end
			bitw = bitw >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.30, built by successive square roots
	function automatic longint unsigned exp2_const(input int k);
		longint unsigned c;
		c = 64'd2 << 30;
		for (int i = 1; i <= k; i++) c = isqrt64(c << 30);
		return c;
	endfunction

endpackage

>>> rtl/bsbp_queue.sv
// bsbp_queue: small job queue between the front and the back
// depends on bsbp_pkg
`timescale 1ns / 1ps

module bsbp_queue #(
	parameter int DEPTH = bsbp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  bsbp_pkg::job_t wr_job,
	output logic          q_full,
	input  logic          rd_en,
	output bsbp_pkg::job_t rd_job,
	output logic          q_empty
);
	import bsbp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/bsbp_front.sv
// bsbp_front: configuration registers, grid position counters and finished
// flags; classifies each cell into a job. depends on bsbp_pkg
`timescale 1ns / 1ps

module bsbp_front #(
	parameter int MAX_STEPS = bsbp_pkg::MAX_STEPS_DEF,
	parameter int MAX_BEAM  = bsbp_pkg::MAX_BEAM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            cell_valid,
	input  bsbp_pkg::cell_t                 item,
	input  logic                            job_full,
	output logic                            job_push,
	output bsbp_pkg::job_t                  job,
	output logic [15:0]                     length_penalty
);
	import bsbp_pkg::*;

	localparam int SW  = $clog2(MAX_STEPS);
	localparam int SLW = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;

	logic [4:0]          out_len_q;
	logic [4:0]          beam_width_q;
	logic [15:0]         pen_q;
	logic [SW-1:0]       step_q;
	logic [SLW-1:0]      slot_q;
	logic [MAX_BEAM-1:0] done_prev_q;
	logic [MAX_BEAM-1:0] done_cur_q;

	int unsigned         len_eff;
	int unsigned         bw_eff;
	logic                oor;
	logic [SW-1:0]       step;
	logic [SLW-1:0]      slot;
	logic [MAX_BEAM-1:0] dprev;
	logic [MAX_BEAM-1:0] dcur;
	logic [SLW-1:0]      par_c;
	logic                fin_in;
	logic                need;
	logic                fin;
	logic                slot_last;
	logic                last_cell;
	logic                accept;
	logic [MAX_BEAM-1:0] dcur_next;

	assign length_penalty = pen_q;

	always_comb begin
		if (out_len_q == '0) len_eff = 1;
		else if (32'(out_len_q) > MAX_STEPS) len_eff = MAX_STEPS;
		else len_eff = 32'(out_len_q);
		if (beam_width_q == '0) bw_eff = 1;
		else if (32'(beam_width_q) > MAX_BEAM) bw_eff = MAX_BEAM;
		else bw_eff = 32'(beam_width_q);
	end

	always_comb begin
		oor   = (32'(step_q) >= len_eff) || (32'(slot_q) >= bw_eff);
		step  = oor ? '0 : step_q;
		slot  = oor ? '0 : slot_q;
		dprev = oor ? '0 : done_prev_q;
		dcur  = oor ? '0 : done_cur_q;
		// parent beyond the beam folds onto the last slot
		if (32'(item.parent_slot) >= bw_eff) par_c = SLW'(bw_eff - 1);
		else par_c = SLW'(item.parent_slot);
		fin_in    = dprev[par_c];
		need      = !fin_in && (item.token == EOS_TOKEN || 32'(step) + 1 == len_eff);
		fin       = fin_in || need;
		slot_last = (32'(slot) + 1 == bw_eff);
		last_cell = slot_last && (32'(step) + 1 == len_eff);
		dcur_next = dcur;
		if (fin) dcur_next[slot] = 1'b1;
	end

	assign accept   = cell_valid && !job_full;
	assign job_push = accept;

	always_comb begin
		job.token      = item.token;
		job.score      = item.score;
		job.parent     = 4'(par_c);
		job.step       = JOB_IDX_W'(step);
		job.slot       = JOB_IDX_W'(slot);
		job.need_score = need;
		job.last_cell  = last_cell;
		job.restart    = (step == '0) && (slot == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len_q    <= 5'd14;
			beam_width_q <= 5'd6;
			pen_q        <= '0;
			step_q       <= '0;
			slot_q       <= '0;
			done_prev_q  <= '0;
			done_cur_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUT_LEN:    out_len_q    <= cfg_data[4:0];
				REG_BEAM_WIDTH: beam_width_q <= cfg_data[4:0];
				REG_LEN_PEN:    pen_q        <= cfg_data;
				default: ;
			endcase
			if (cfg_index == REG_OUT_LEN || cfg_index == REG_BEAM_WIDTH ||
			    cfg_index == REG_LEN_PEN) begin
				step_q      <= '0;
				slot_q      <= '0;
				done_prev_q <= '0;
				done_cur_q  <= '0;
			end
		end else if (accept) begin
			if (slot_last) begin
				slot_q      <= '0;
				done_cur_q  <= '0;
				done_prev_q <= last_cell ? '0 : dcur_next;
				step_q      <= last_cell ? '0 : step + SW'(1);
			end else begin
				slot_q     <= slot + SLW'(1);
				step_q     <= step;
				done_cur_q <= dcur_next;
				done_prev_q <= dprev;
			end
		end
	end

endmodule

>>> rtl/bsbp_back.sv
// bsbp_back: grid stores, length-penalty unit, best tracking, backtrace and
// result register. depends on bsbp_pkg
`timescale 1ns / 1ps

module bsbp_back #(
	parameter int MAX_STEPS = bsbp_pkg::MAX_STEPS_DEF,
	parameter int MAX_BEAM  = bsbp_pkg::MAX_BEAM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bsbp_pkg::job_t    q_job,
	output logic              q_pop,
	input  logic [15:0]       length_penalty,
	output logic              empty,
	input  logic              pop,
	output bsbp_pkg::result_t result
);
	import bsbp_pkg::*;

	localparam int SW    = $clog2(MAX_STEPS);
	localparam int SLW   = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;
	localparam int DEPTH = MAX_STEPS * MAX_BEAM;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_STEPS + 1);
	localparam int KW    = $clog2(RESULT_CAP + 1);

	bsbp_state_t state_q, state_d;

	logic [23:0] tok_mem [DEPTH];
	logic [3:0]  par_mem [DEPTH];
	logic [23:0] rd_tok_q;
	logic [3:0]  rd_par_q;

	logic [LOG_W-1:0] log_rom [MAX_STEPS];
	logic [31:0]      exp_c   [16];

	job_t               job_q;
	logic signed [39:0] prod_q;
	logic [30:0]        y_q;
	logic [3:0]         exp_k_q;
	logic [62:0]        m_q;
	logic [31:0]        r_q;

	logic [SW-1:0]       best_step_q;
	logic [SLW-1:0]      best_slot_q;
	logic signed [31:0]  best_value_q;
	logic                best_seen_q;

	logic [SW-1:0]  tr_s_q;
	logic [SLW-1:0] tr_b_q;
	logic [NW-1:0]  n_q;
	logic           eos_seen_q;
	logic [NW-1:0]  eos_pos_q;
	logic [23:0]    stack_q [MAX_STEPS];
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  cnt_q;
	logic [SW-1:0]  idx_q;

	logic    out_valid_q;
	result_t out_q;

	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic signed [40:0] nprod;
	logic [15:0]        frac_e;
	logic signed [14:0] sh;
	logic [62:0]        lim;
	logic [62:0]        r63;
	logic [6:0]         ls;
	logic signed [32:0] v;
	logic               better;
	logic [62:0]        y_prod;
	logic               out_free;
	logic               tr_go;
	logic               emit_fire;
	logic               emit_done;
	logic [NW-1:0]      k_raw;

	for (genvar i = 0; i < MAX_STEPS; i++) begin : g_log
		localparam longint unsigned LV = fx_log2(i + 1);
		assign log_rom[i] = LOG_W'(LV);
	end

	for (genvar i = 0; i < 16; i++) begin : g_exp
		localparam longint unsigned CV = exp2_const(i + 1);
		assign exp_c[i] = 32'(CV);
	end

	assign wr_addr = AW'(AW'(q_job.step[SW-1:0]) * AW'(MAX_BEAM)) + AW'(q_job.slot[SLW-1:0]);
	assign rd_addr = AW'(AW'(tr_s_q) * AW'(MAX_BEAM)) + AW'(tr_b_q);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tok_mem[wr_addr] <= q_job.token;
			par_mem[wr_addr] <= q_job.parent;
		end
		rd_tok_q <= tok_mem[rd_addr];
		rd_par_q <= par_mem[rd_addr];
	end

	// penalty datapath
	always_comb begin
		nprod  = -$signed({prod_q[39], prod_q});
		frac_e = nprod[27:12];
		sh     = 15'sd30 - $signed({{2{nprod[40]}}, nprod[40:28]});
		y_prod = 63'(64'(y_q) * 64'(exp_c[exp_k_q]));
		lim    = job_q.score[31] ? 63'(33'h0_8000_0000) : 63'(33'h0_7FFF_FFFF);
		ls     = 7'(-sh);
		r63    = '0;
		if (sh >= 15'sd63) begin
			r63 = '0;
		end else if (sh >= 15'sd0) begin
			r63 = m_q >> sh[5:0];
			if (r63 > lim) r63 = lim;
		end else if (ls >= 7'd40 || m_q > (lim >> ls)) begin
			r63 = lim;
		end else begin
			r63 = m_q << ls;
		end
		v      = job_q.score[31] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
		better = !best_seen_q || (v > 33'(best_value_q));
	end

	always_comb begin
		out_free  = !out_valid_q || pop;
		tr_go     = (tr_s_q != '0) && (32'(n_q) < MAX_STEPS);
		if (eos_seen_q) k_raw = n_q - NW'(1) - eos_pos_q;
		else k_raw = n_q;
		emit_done = (k_q == '0) || (cnt_q == k_q - KW'(1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_job.need_score) state_d = B_LOG;
					else if (q_job.last_cell) state_d = B_TR_INIT;
				end
			end
			B_LOG:     state_d = B_EXP;
			B_EXP:     if (exp_k_q == 4'd15) state_d = B_MAG;
			B_MAG:     state_d = B_SAT;
			B_SAT:     state_d = B_CMP;
			B_CMP:     state_d = job_q.last_cell ? B_TR_INIT : B_IDLE;
			B_TR_INIT: state_d = B_TR_RD;
			B_TR_RD:   state_d = tr_go ? B_TR_WB : B_TR_FIN;
			B_TR_WB:   state_d = B_TR_RD;
			B_TR_FIN:  state_d = B_EMIT;
			B_EMIT:    if (out_free && emit_done) state_d = B_IDLE;
			default:   state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == B_IDLE) && !q_empty;
		emit_fire = (state_q == B_EMIT) && out_free;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_job;
		if (state_q == B_LOG) begin
			prod_q <= $signed({{24{length_penalty[15]}}, length_penalty}) *
			          $signed({17'd0, log_rom[job_q.step[SW-1:0]]});
		end
		if (state_q == B_MAG) begin
			m_q <= 63'({32'd0, 32'(job_q.score[31] ? -job_q.score : job_q.score)} *
			           64'(y_q));
		end
		if (state_q == B_SAT) r_q <= r63[31:0];
		if (state_q == B_TR_WB) stack_q[n_q[SW-1:0]] <= rd_tok_q;
		if (emit_fire) begin
			if (k_q == '0) begin
				out_q.out_token <= '0;
				out_q.is_last   <= 1'b1;
				out_q.is_empty  <= 1'b1;
			end else begin
				out_q.out_token <= stack_q[idx_q];
				out_q.is_last   <= (cnt_q == k_q - KW'(1));
				out_q.is_empty  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			y_q          <= '0;
			exp_k_q      <= '0;
			best_step_q  <= '0;
			best_slot_q  <= '0;
			best_value_q <= '0;
			best_seen_q  <= 1'b0;
			tr_s_q       <= '0;
			tr_b_q       <= '0;
			n_q          <= '0;
			eos_seen_q   <= 1'b0;
			eos_pos_q    <= '0;
			k_q          <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_job.restart) begin
				best_step_q  <= '0;
				best_slot_q  <= '0;
				best_value_q <= '0;
				best_seen_q  <= 1'b0;
			end
			if (state_q == B_LOG) begin
				y_q     <= 31'h4000_0000;
				exp_k_q <= '0;
			end
			if (state_q == B_EXP) begin
				// one fractional exponent bit per cycle, most significant first
				if (frac_e[4'd15 - exp_k_q]) y_q <= 31'(y_prod >> 30);
				exp_k_q <= exp_k_q + 4'd1;
			end
			if (state_q == B_CMP && better) begin
				best_seen_q  <= 1'b1;
				best_value_q <= v[31:0];
				best_step_q  <= job_q.step[SW-1:0];
				best_slot_q  <= job_q.slot[SLW-1:0];
			end
			if (state_q == B_TR_INIT) begin
				tr_s_q     <= best_step_q;
				tr_b_q     <= best_slot_q;
				n_q        <= '0;
				eos_seen_q <= 1'b0;
			end
			if (state_q == B_TR_WB) begin
				if (rd_tok_q == EOS_TOKEN) begin
					eos_seen_q <= 1'b1;
					eos_pos_q  <= n_q;
				end
				tr_b_q <= SLW'(rd_par_q);
				tr_s_q <= tr_s_q - SW'(1);
				n_q    <= n_q + NW'(1);
			end
			if (state_q == B_TR_FIN) begin
				k_q          <= (32'(k_raw) > RESULT_CAP) ? KW'(RESULT_CAP) : KW'(k_raw);
				idx_q        <= SW'(n_q - NW'(1));
				cnt_q        <= '0;
				best_step_q  <= '0;
				best_slot_q  <= '0;
				best_value_q <= '0;
				best_seen_q  <= 1'b0;
			end
			if (emit_fire) begin
				idx_q <= idx_q - SW'(1);
				cnt_q <= cnt_q + KW'(1);
			end
			if (emit_fire) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/beam_search_best_path_trace.sv
// Beam-search best-path tracer, top level: front, job queue and back
// depends on bsbp_pkg, bsbp_front, bsbp_queue, bsbp_back
`timescale 1ns / 1ps

// Cells are pushed step-major, slot-minor; the front takes one per cycle,
// while the queue has room, into a four-entry job queue. The back handles a
// cell that is not scored as it pops it; a scored one then passes the log
// lookup and multiply, the bit-serial 2^f product, the magnitude multiply,
// shift and compare. After the last cell of a grid the back walks the
// parents, a read and a write-back per step through the registered grid
// memory, then delivers one result per cycle while the result register is
// free. Configuration writes drop any grid in progress.
module beam_search_best_path_trace #(
	parameter int MAX_STEPS = bsbp_pkg::MAX_STEPS_DEF,
	parameter int MAX_BEAM  = bsbp_pkg::MAX_BEAM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  bsbp_pkg::cell_t                 item,
	output logic                            empty,
	input  logic                            pop,
	output bsbp_pkg::result_t               result
);
	import bsbp_pkg::*;

	job_t        fq_job;
	job_t        bq_job;
	logic        fq_push;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	logic [15:0] pen;

	assign full = q_full;

	bsbp_front #(
		.MAX_STEPS(MAX_STEPS),
		.MAX_BEAM (MAX_BEAM)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cell_valid    (push),
		.item          (item),
		.job_full      (q_full),
		.job_push      (fq_push),
		.job           (fq_job),
		.length_penalty(pen)
	);

	bsbp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fq_push),
		.wr_job (fq_job),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_job (bq_job),
		.q_empty(q_empty)
	);

	bsbp_back #(
		.MAX_STEPS(MAX_STEPS),
		.MAX_BEAM (MAX_BEAM)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (bq_job),
		.q_pop         (q_pop),
		.length_penalty(pen),
		.empty         (empty),
		.pop           (pop),
		.result        (result)
	);

endmodule
